[rtl/tmvr_pkg.sv]
// ----------------------------------------------------------------------------
// tmvr_pkg: shared types and constants of the torus memory voter
// Geometry limits, field widths, register and command codes, the payload
// structs of both channels and the sequencer state encoding.
// ----------------------------------------------------------------------------
package tmvr_pkg;

  // geometry and arithmetic limits
  localparam int MAX_SIDE     = 64;
  localparam int RANDOM_BITS  = 16;
  localparam int NODE_SLOTS   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W       = $clog2(NODE_SLOTS);
  localparam int TOTAL_W      = $clog2(NODE_SLOTS + 1);
  localparam int SIDE_W       = $clog2(MAX_SIDE + 1);
  localparam int POS_W        = $clog2(MAX_SIDE);
  localparam int DIV_CNT_W    = $clog2(ADDR_W + 1);

  // fixed field widths
  localparam int SIDE_REG_W   = 7;
  localparam int WEIGHT_W     = 17;
  localparam int CFG_W        = 17;
  localparam int RF_IN_W      = 16;
  localparam int NODE_INDEX_W = 12;
  localparam int COUNT_W      = 32;
  localparam int STATE_W      = 2;

  // arithmetic widths
  localparam int RF_W   = (RANDOM_BITS < RF_IN_W) ? RANDOM_BITS : RF_IN_W;
  localparam int NB_W   = 3;                  // neighbor count, 0..4
  localparam int PROD_W = 19;                 // up to 4 * 2^16
  localparam int CMP_W  = RANDOM_BITS + 34;
  localparam logic [WEIGHT_W-1:0] Q16_ONE = WEIGHT_W'(65536);

  // reset values of the configuration registers
  localparam logic [SIDE_REG_W-1:0] SIDE_RESET   = SIDE_REG_W'(64);
  localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET = WEIGHT_W'(32768);

  // configuration register indexes
  localparam logic [0:0] REG_SIDE_LENGTH   = 1'b0;
  localparam logic [0:0] REG_MEMORY_WEIGHT = 1'b1;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // read slots of one update: own node, then the four neighbors
  localparam logic [2:0] RD_OWN   = 3'd0;
  localparam logic [2:0] RD_LEFT  = 3'd1;
  localparam logic [2:0] RD_RIGHT = 3'd2;
  localparam logic [2:0] RD_UP    = 3'd3;
  localparam logic [2:0] RD_DOWN  = 3'd4;
  localparam logic [2:0] RD_DRAIN = 3'd5;

  typedef struct packed {
    logic              command;
    logic              opinion;
    logic [RF_IN_W-1:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [NODE_INDEX_W-1:0] node_index;
    logic [STATE_W-1:0]      node_state;
    logic                    round_done;
    logic                    unanimous;
    logic [COUNT_W-1:0]      round_count;
  } out_item_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
    logic [POS_W-1:0] rem;
  } div_res_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_READ  = 6'b001000,
    ST_CALC  = 6'b010000,
    ST_WRITE = 6'b100000
  } fsm_t;

endpackage

[rtl/tmvr_ram.sv]
// ----------------------------------------------------------------------------
// tmvr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tmvr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tmvr_div.sv]
// ----------------------------------------------------------------------------
// tmvr_div: radix-2 restoring divider for node index by side length
// Splits a raster index into row (quotient) and column (remainder), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmvr_div
  import tmvr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [SIDE_W-1:0] divisor,
  output div_res_t          res
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [ADDR_W-1:0]    quot_r;
  logic [SIDE_W-1:0]    rem_r;

  logic [SIDE_W:0]   trial;
  logic              fits;
  logic [SIDE_W:0]   diff;

  // shift in the next dividend bit, subtract when the divisor fits
  assign trial = {rem_r, quot_r[ADDR_W-1]};
  assign fits  = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(ADDR_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[ADDR_W-2:0], fits};
      rem_r  <= fits ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r[POS_W-1:0];
  assign res.rem  = rem_r[POS_W-1:0];

endmodule

[rtl/torus_memory_voter_round.sv]
// ----------------------------------------------------------------------------
// torus_memory_voter_round: voter model with memory on a square torus
// Node states live in two banks; updates read the snapshot bank and write
// the other one, loads write both. One node per transaction, raster order.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------
//  in_*      input      in_valid / in_stall  in_item_t  (command, opinion, r)
//  out_*     output     out_valid/out_stall  out_item_t (index, state, flags)
//  cfg_*     input      cfg_we               cfg_index, cfg_data
//
//  One item at a time. A load goes from accept to the commit; an update
//  first makes five reads of the snapshot bank through its single read
//  port, then one drain step and one multiply step before the commit.
//  After a side_length write the first item adds the row/column split,
//  ADDR_W (12) divider steps and the done step, unless it restarts at node 0.
//  Reset: rst_n is synchronous; control state clears at once, the node
//  banks are not cleared and must be loaded before they are read.
//  Stalls: the result waits in the output register; a new transaction is
//  taken while it waits, and the commit holds until the register frees.
//
module torus_memory_voter_round
  import tmvr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  fsm_t                  state_r, state_nxt;
  in_item_t              item_r, item_nxt;

  logic [SIDE_REG_W-1:0] side_r;
  logic [WEIGHT_W-1:0]   weight_r;
  logic [SIDE_W-1:0]     m_r;
  logic [TOTAL_W-1:0]    tot_r;
  logic [WEIGHT_W-1:0]   w_r;
  logic                  dirty_r, dirty_nxt;

  logic [ADDR_W-1:0]     ptr_r, ptr_nxt;
  logic [POS_W-1:0]      row_r, row_nxt;
  logic [POS_W-1:0]      col_r, col_nxt;
  logic                  bank_r, bank_nxt;
  logic [COUNT_W-1:0]    rounds_r, rounds_nxt;
  logic [STATE_W-1:0]    first_r, first_nxt;
  logic                  alleq_r, alleq_nxt;

  logic [2:0]            rd_k_r, rd_k_nxt;
  logic [NB_W-1:0]       oldc_r, oldc_nxt;
  logic [NB_W-1:0]       curc_r, curc_nxt;
  logic                  own_r, own_nxt;
  logic [PROD_W-1:0]     prod_old_r, prod_old_nxt;
  logic [PROD_W-1:0]     prod_cur_r, prod_cur_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  // --------------------------------------------------------------------------
  // combinational helpers
  // --------------------------------------------------------------------------
  logic [SIDE_W-1:0]     m_eff;
  logic [WEIGHT_W-1:0]   w_eff;
  logic [WEIGHT_W-1:0]   w_inv;
  logic [ADDR_W-1:0]     m_a;
  logic [ADDR_W-1:0]     tot_minus_m;
  logic                  col_last;
  logic                  row_last;
  logic [ADDR_W-1:0]     addr_left, addr_right, addr_up, addr_down;
  logic [ADDR_W-1:0]     rd_addr;
  logic [STATE_W-1:0]    rd_even, rd_odd, rd_data;
  logic                  ram_we_even, ram_we_odd;
  logic [STATE_W-1:0]    wr_state;
  logic                  div_start;
  div_res_t              div_res;

  logic                  out_free;
  logic                  is_update;
  logic                  last_node;
  logic [PROD_W-1:0]     rhs_sum;
  logic [CMP_W-1:0]      lhs;
  logic [CMP_W-1:0]      rhs;
  logic                  vote;
  logic                  agree;

  // clamp the registers to their usable ranges
  always_comb begin
    if (side_r < SIDE_REG_W'(2)) begin
      m_eff = SIDE_W'(2);
    end else if (int'(side_r) > MAX_SIDE) begin
      m_eff = SIDE_W'(MAX_SIDE);
    end else begin
      m_eff = SIDE_W'(side_r);
    end
    w_eff = (weight_r > Q16_ONE) ? Q16_ONE : weight_r;
  end

  assign w_inv       = Q16_ONE - w_r;
  assign m_a         = ADDR_W'(m_r);
  assign tot_minus_m = ADDR_W'(tot_r) - m_a;
  assign col_last    = (SIDE_W'(col_r) == m_r - 1'b1);
  assign row_last    = (SIDE_W'(row_r) == m_r - 1'b1);

  // wrapped neighbors, worked out from the raster index and row/column edges
  assign addr_left  = (col_r == '0) ? ptr_r + (m_a - 1'b1) : ptr_r - 1'b1;
  assign addr_right = col_last      ? ptr_r - (m_a - 1'b1) : ptr_r + 1'b1;
  assign addr_up    = (row_r == '0) ? ptr_r + tot_minus_m  : ptr_r - m_a;
  assign addr_down  = row_last      ? ptr_r - tot_minus_m  : ptr_r + m_a;

  always_comb begin
    case (rd_k_r)
      RD_OWN:   rd_addr = ptr_r;
      RD_LEFT:  rd_addr = addr_left;
      RD_RIGHT: rd_addr = addr_right;
      RD_UP:    rd_addr = addr_up;
      default:  rd_addr = addr_down;
    endcase
  end

  // the snapshot is the active bank
  assign rd_data = bank_r ? rd_odd : rd_even;

  assign out_free  = !out_valid_r || !out_stall;
  assign is_update = (item_r.command == CMD_UPDATE);
  assign last_node = ((TOTAL_W'(ptr_r) + 1'b1) >= tot_r);

  // vote: 4*r*2^16 <= old*(1-w) + cur*w, both sides scaled to integers
  assign rhs_sum = prod_old_r + prod_cur_r;
  assign lhs     = CMP_W'(item_r.random_fraction[RF_W-1:0]) << 18;
  assign rhs     = CMP_W'(rhs_sum) << RANDOM_BITS;
  assign vote    = (lhs <= rhs);

  assign wr_state = is_update ? {own_r, vote} : {2{item_r.opinion}};

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    dirty_nxt     = dirty_r;
    ptr_nxt       = ptr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    bank_nxt      = bank_r;
    rounds_nxt    = rounds_r;
    first_nxt     = first_r;
    alleq_nxt     = alleq_r;
    rd_k_nxt      = rd_k_r;
    oldc_nxt      = oldc_r;
    curc_nxt      = curc_r;
    own_nxt       = own_r;
    prod_old_nxt  = prod_old_r;
    prod_cur_nxt  = prod_cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we_even   = 1'b0;
    ram_we_odd    = 1'b0;
    div_start     = 1'b0;
    agree         = 1'b0;

    // a side_length write invalidates the row/column split of the pointer
    if (cfg_we && (cfg_index == REG_SIDE_LENGTH)) begin
      dirty_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_PREP;
        end
      end

      ST_PREP: begin
        rd_k_nxt = RD_OWN;
        oldc_nxt = '0;
        curc_nxt = '0;
        if (TOTAL_W'(ptr_r) >= tot_r) begin
          // torus shrank under the pointer: restart at node 0
          ptr_nxt   = '0;
          row_nxt   = '0;
          col_nxt   = '0;
          dirty_nxt = 1'b0;
          state_nxt = is_update ? ST_READ : ST_WRITE;
        end else if (dirty_r) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = is_update ? ST_READ : ST_WRITE;
        end
      end

      ST_DIV: begin
        if (div_res.done) begin
          row_nxt   = div_res.quot;
          col_nxt   = div_res.rem;
          dirty_nxt = 1'b0;
          state_nxt = is_update ? ST_READ : ST_WRITE;
        end
      end

      ST_READ: begin
        // issue one read a cycle, take the data of the previous slot
        rd_k_nxt = rd_k_r + 1'b1;
        if (rd_k_r == RD_LEFT) begin
          own_nxt = rd_data[0];
        end else if (rd_k_r != RD_OWN) begin
          oldc_nxt = oldc_r + NB_W'(rd_data[1]);
          curc_nxt = curc_r + NB_W'(rd_data[0]);
        end
        if (rd_k_r == RD_DRAIN) begin
          state_nxt = ST_CALC;
        end
      end

      ST_CALC: begin
        prod_old_nxt = PROD_W'(oldc_r) * PROD_W'(w_inv);
        prod_cur_nxt = PROD_W'(curc_r) * PROD_W'(w_r);
        state_nxt    = ST_WRITE;
      end

      ST_WRITE: begin
        if (out_free) begin
          // loads go to both banks, updates to the bank that is not the snapshot
          ram_we_even = !is_update || bank_r;
          ram_we_odd  = !is_update || !bank_r;

          if (ptr_r == '0) begin
            first_nxt = wr_state;
            alleq_nxt = 1'b1;
          end else if (wr_state != first_r) begin
            alleq_nxt = 1'b0;
          end

          if (last_node) begin
            agree = alleq_nxt && ((first_nxt == 2'b00) || (first_nxt == 2'b11));
            if (is_update) begin
              bank_nxt = !bank_r;
              if (rounds_r != '1) begin
                rounds_nxt = rounds_r + 1'b1;
              end
            end
            ptr_nxt = '0;
            row_nxt = '0;
            col_nxt = '0;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
            if (col_last) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end

          out_valid_nxt            = 1'b1;
          out_data_nxt.node_index  = NODE_INDEX_W'(ptr_r);
          out_data_nxt.node_state  = wr_state;
          out_data_nxt.round_done  = last_node;
          out_data_nxt.unanimous   = agree;
          out_data_nxt.round_count = rounds_nxt;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= SIDE_RESET;
      weight_r    <= WEIGHT_RESET;
      dirty_r     <= 1'b0;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      bank_r      <= 1'b0;
      rounds_r    <= '0;
      first_r     <= '0;
      alleq_r     <= 1'b1;
      rd_k_r      <= RD_OWN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      ptr_r       <= ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      bank_r      <= bank_nxt;
      rounds_r    <= rounds_nxt;
      first_r     <= first_nxt;
      alleq_r     <= alleq_nxt;
      rd_k_r      <= rd_k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SIDE_LENGTH:   side_r   <= cfg_data[SIDE_REG_W-1:0];
          REG_MEMORY_WEIGHT: weight_r <= cfg_data[WEIGHT_W-1:0];
          default:           side_r   <= side_r;
        endcase
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    m_r        <= m_eff;
    tot_r      <= TOTAL_W'(m_eff) * TOTAL_W'(m_eff);
    w_r        <= w_eff;
    oldc_r     <= oldc_nxt;
    curc_r     <= curc_nxt;
    own_r      <= own_nxt;
    prod_old_r <= prod_old_nxt;
    prod_cur_r <= prod_cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // node banks and row/column divider
  // --------------------------------------------------------------------------
  tmvr_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NODE_SLOTS)
  ) u_bank_even (
    .clk   (clk),
    .we    (ram_we_even),
    .waddr (ptr_r),
    .wdata (wr_state),
    .raddr (rd_addr),
    .rdata (rd_even)
  );

  tmvr_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NODE_SLOTS)
  ) u_bank_odd (
    .clk   (clk),
    .we    (ram_we_odd),
    .waddr (ptr_r),
    .wdata (wr_state),
    .raddr (rd_addr),
    .rdata (rd_odd)
  );

  tmvr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ptr_r),
    .divisor  (m_r),
    .res      (div_res)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_WRITE))
    else $error("result appeared without a commit");

  a_even_write_not_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we_even && !ram_we_odd) |-> bank_r)
    else $error("update wrote the even snapshot bank");

  a_odd_write_not_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we_odd && !ram_we_even) |-> !bank_r)
    else $error("update wrote the odd snapshot bank");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (TOTAL_W'(ptr_r) < tot_r))
    else $error("node pointer beyond the torus during reads");

  a_rounds_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (rounds_r >= $past(rounds_r)))
    else $error("round counter went backwards");

  a_agree_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.unanimous) |-> out_data.round_done)
    else $error("agreement flagged before the end of a pass");

endmodule

[bench/torus_vote_checker.sv]
// ----------------------------------------------------------------------------
// torus_vote_checker: result checker for the torus memory voter
// Watches the configuration port and both channels, keeps its own copy of
// the two node banks, predicts each node result and compares it field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module torus_vote_checker
  import tmvr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatches,
  output int               results_due
);

  logic [STATE_W-1:0]    node_store [2][NODE_SLOTS];
  logic                  snap_bank;
  int unsigned           visit_ptr;
  logic [COUNT_W-1:0]    rounds_seen;
  logic [STATE_W-1:0]    lead_state;
  logic                  all_match;
  logic [SIDE_REG_W-1:0] side_reg;
  logic [WEIGHT_W-1:0]   weight_reg;
  out_item_t             awaited_nodes [$];
  int                    error_total = 0;
  int                    queue_depth = 0;

  assign mismatches  = error_total;
  assign results_due = queue_depth;

  // nodes are never read before they are written; start them at zero anyway
  initial begin
    foreach (node_store[b, i]) node_store[b][i] = '0;
  end

  task automatic log_mismatch(input string msg);
    error_total++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
                             input logic [COUNT_W-1:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Handle one node transaction: update the banks and return the result.
  function automatic out_item_t vote_next_node(input in_item_t item);
    int unsigned        m, w, total, slot, row, col, old_votes, cur_votes;
    int unsigned        nbr [4];
    logic [STATE_W-1:0] seen, fresh;
    logic [63:0]        rf, lhs, rhs;
    out_item_t          res;
    m = side_reg;
    if (m < 2) m = 2;
    if (m > MAX_SIDE) m = MAX_SIDE;
    w = weight_reg;
    if (w > Q16_ONE) w = Q16_ONE;
    total = m * m;
    slot  = (visit_ptr >= total) ? 0 : visit_ptr;
    if (item.command == CMD_LOAD) begin
      fresh = {STATE_W{item.opinion}};
      node_store[0][slot] = fresh;
      node_store[1][slot] = fresh;
    end else begin
      row    = slot / m;
      col    = slot % m;
      nbr[0] = row * m + (col + m - 1) % m;
      nbr[1] = row * m + (col + 1) % m;
      nbr[2] = ((row + m - 1) % m) * m + col;
      nbr[3] = ((row + 1) % m) * m + col;
      old_votes = 0;
      cur_votes = 0;
      foreach (nbr[k]) begin
        seen = node_store[snap_bank][nbr[k]];
        old_votes += seen[1];
        cur_votes += seen[0];
      end
      rf  = 64'(item.random_fraction) & ((64'd1 << RANDOM_BITS) - 64'd1);
      lhs = (64'd4 * rf) << 16;
      rhs = (64'(old_votes) * (64'(Q16_ONE) - 64'(w)) + 64'(cur_votes) * 64'(w))
            << RANDOM_BITS;
      fresh = {node_store[snap_bank][slot][0], lhs <= rhs};
      node_store[!snap_bank][slot] = fresh;
    end

    if (slot == 0) begin
      lead_state = fresh;
      all_match  = 1'b1;
    end else if (fresh != lead_state) begin
      all_match = 1'b0;
    end

    res.node_index = NODE_INDEX_W'(slot);
    res.node_state = fresh;
    res.round_done = 1'b0;
    res.unanimous  = 1'b0;
    if (slot + 1 >= total) begin
      res.round_done = 1'b1;
      res.unanimous  = all_match && (lead_state == '0 || lead_state == '1);
      // only a pass closed by an update swaps the banks and counts
      if (item.command == CMD_UPDATE) begin
        snap_bank = !snap_bank;
        if (rounds_seen != '1) rounds_seen++;
      end
      visit_ptr = 0;
    end else begin
      visit_ptr = slot + 1;
    end
    res.round_count = rounds_seen;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      snap_bank   = 1'b0;
      visit_ptr   = 0;
      rounds_seen = '0;
      lead_state  = '0;
      all_match   = 1'b1;
      side_reg    = SIDE_RESET;
      weight_reg  = WEIGHT_RESET;
      awaited_nodes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SIDE_LENGTH:   side_reg   = cfg_data[SIDE_REG_W-1:0];
          REG_MEMORY_WEIGHT: weight_reg = cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        awaited_nodes.push_back(vote_next_node(in_data));
      if (out_valid && !out_stall) begin
        if (awaited_nodes.size() == 0) begin
          log_mismatch("result with no transaction awaiting it");
        end else begin
          want = awaited_nodes.pop_front();
          check_field("node_index", out_data.node_index, want.node_index);
          check_field("node_state", out_data.node_state, want.node_state);
          check_field("round_done", out_data.round_done, want.round_done);
          check_field("unanimous", out_data.unanimous, want.unanimous);
          check_field("round_count", out_data.round_count, want.round_count);
        end
      end
    end
    queue_depth = awaited_nodes.size();
  end

endmodule

[bench/torus_memory_voter_round_test.sv]
// ----------------------------------------------------------------------------
// torus_memory_voter_round_test: stimulus and verdict for the torus voter
// Loads and updates node opinions through the input channel under random
// idling of both sides, across several torus sizes and memory weights, and
// lets a side checker predict and compare every result.
// ----------------------------------------------------------------------------
module torus_memory_voter_round_test;
  import tmvr_pkg::*;

  // Longest quiet stretch of a correct run: a divider restart plus an
  // update plus the tails of an 84 percent sender gap and receiver stall.
  // Allow far more than that.
  localparam int QUIET_LIMIT = 4000;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_index = REG_SIDE_LENGTH;
  logic [CFG_W-1:0] cfg_data  = '0;
  int               mismatches;
  int               results_due;

  // idling odds, in percent, for the sender and the receiver
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  // Stimulus-side view of the torus: which slots were ever loaded, the
  // effective side and the node the next transaction will land on. An update
  // is only issued once every node of the current torus has been loaded, so
  // no unwritten node is ever read.
  bit          node_loaded [NODE_SLOTS];
  int unsigned eff_side      = MAX_SIDE;
  int unsigned next_ptr      = 0;
  int unsigned unloaded_left = NODE_SLOTS;

  // flavor of the current pass, drawn when the pointer comes back to node 0
  int          pass_flavor  = 0;
  logic        pass_opinion = 1'b0;
  bit          pass_noisy   = 1'b0;

  torus_memory_voter_round dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  torus_vote_checker vote_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result channel at random; the odds follow the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned node_count();
    return eff_side * eff_side;
  endfunction

  // node the next transaction hits; a shrunken torus restarts at node 0
  function automatic int unsigned upcoming_slot();
    return (next_ptr >= node_count()) ? 0 : next_ptr;
  endfunction

  // Write both registers back to back while the block is idle, then recount
  // the nodes of the new torus that still need a load.
  task automatic set_config(input logic [SIDE_REG_W-1:0] side_v,
                            input logic [WEIGHT_W-1:0] weight_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIDE_LENGTH;
    cfg_data  <= CFG_W'(side_v);
    @(posedge clk);
    cfg_index <= REG_MEMORY_WEIGHT;
    cfg_data  <= CFG_W'(weight_v);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_side = (side_v < 2) ? 2 : (side_v > MAX_SIDE) ? MAX_SIDE : side_v;
    unloaded_left = 0;
    for (int unsigned i = 0; i < node_count(); i++)
      if (!node_loaded[i]) unloaded_left++;
  endtask

  // Offer one transaction, idling first at the sender's odds, and hold it
  // until the block takes it. Valid stays high from one transaction into the
  // next unless a gap is drawn.
  task automatic push_node(input logic cmd, input logic op,
                           input logic [RF_IN_W-1:0] rf);
    in_item_t    item;
    int unsigned slot;
    item.command         = cmd;
    item.opinion         = op;
    item.random_fraction = rf;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted: advance the stimulus-side pointer
    slot = upcoming_slot();
    if (cmd == CMD_LOAD && !node_loaded[slot]) begin
      node_loaded[slot] = 1'b1;
      unloaded_left--;
    end
    next_ptr = (slot + 1 >= node_count()) ? 0 : slot + 1;
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random phase: new registers, then passes of mostly updates with
  // random content. Some passes are noisy and get loads mixed in, which
  // ends some of them by a load; a torus with unloaded nodes gets loads only.
  task automatic run_phase(input logic [SIDE_REG_W-1:0] side_v,
                           input logic [WEIGHT_W-1:0] weight_v, input int items);
    logic             cmd;
    logic             op;
    logic [RF_IN_W-1:0] rf;
    settle();
    set_config(side_v, weight_v);
    repeat (items) begin
      if (upcoming_slot() == 0) begin
        pass_flavor  = $urandom_range(9);
        pass_opinion = 1'($urandom_range(1));
        pass_noisy   = ($urandom_range(99) < 30);
      end
      if (unloaded_left == 0 && !(pass_noisy && $urandom_range(99) < 25))
        cmd = CMD_UPDATE;
      else
        cmd = CMD_LOAD;
      // uniform opinions and extreme fractions steer passes toward agreement
      op = (pass_flavor < 4) ? pass_opinion : 1'($urandom_range(1));
      if (pass_flavor < 3)
        rf = '0;
      else if (pass_flavor < 5)
        rf = '1;
      else
        rf = RF_IN_W'($urandom_range((1 << RF_IN_W) - 1));
      push_node(cmd, op, rf);
    end
  endtask

  initial begin
    // hold reset at the start, then release it for good
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 35;
    stall_pct    = 84;

    // Directed: side below the minimum (clamped to 2) and zero weight.
    // A unanimous load pass, a full update pass with zero fraction, one with
    // the largest fraction, then a pass ended by loads.
    set_config(SIDE_REG_W'(1), WEIGHT_W'(0));
    repeat (4) push_node(CMD_LOAD, 1'b1, '0);
    repeat (4) push_node(CMD_UPDATE, 1'b0, '0);
    repeat (4) push_node(CMD_UPDATE, 1'b1, '1);
    push_node(CMD_UPDATE, 1'b0, RF_IN_W'(16'h8000));
    push_node(CMD_UPDATE, 1'b1, RF_IN_W'(16'h4000));
    push_node(CMD_LOAD, 1'b0, '0);
    push_node(CMD_LOAD, 1'b1, '1);

    // weight above one (clamped); leave the pointer at node 6 of a 3x3 torus
    settle();
    set_config(SIDE_REG_W'(3), '1);
    for (int i = 0; i < 6; i++) push_node(CMD_LOAD, 1'(i % 2 == 0), '1);

    // shrink to 2x2: the pointer is out of range and restarts at node 0
    settle();
    set_config(SIDE_REG_W'(2), Q16_ONE);
    push_node(CMD_UPDATE, 1'b0, '0);
    push_node(CMD_UPDATE, 1'b1, RF_IN_W'(16'h3FFF));
    push_node(CMD_UPDATE, 1'b0, RF_IN_W'(16'h7FFF));
    push_node(CMD_UPDATE, 1'b1, '1);

    // random phases, sender idling lightly and receiver heavily
    run_phase(SIDE_REG_W'(5), WEIGHT_W'(32768), 250);
    run_phase(SIDE_REG_W'(2), WEIGHT_W'(0), 150);

    // the other way round
    send_gap_pct = 84;
    stall_pct    = 35;
    run_phase(SIDE_REG_W'(8), Q16_ONE, 300);
    run_phase(SIDE_REG_W'(3), WEIGHT_W'(1), 200);

    // no idling; a side above the limit clamps to the largest torus, which
    // only gets part of one load pass, then a smaller torus restarts at node 0
    send_gap_pct = 0;
    stall_pct    = 0;
    run_phase(SIDE_REG_W'(0), '1, 200);
    run_phase('1, WEIGHT_W'(12345), 300);
    run_phase(SIDE_REG_W'(4), WEIGHT_W'(65535), 200);

    // drain, give stray results a chance to show up, then decide
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[torus_memory_voter_round.f]
rtl/tmvr_pkg.sv
rtl/tmvr_ram.sv
rtl/tmvr_div.sv
rtl/torus_memory_voter_round.sv
bench/torus_vote_checker.sv
bench/torus_memory_voter_round_test.sv
